### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrs assertion failed");
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("qrs forbidden condition seen");
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop)
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

### hw/rtl/qrs_pkg.sv
package qrs_pkg;

    localparam int D_W   = 66;  // discriminant magnitude bits
    localparam int R_W   = 33;  // square root bits
    localparam int N_W   = 34;  // divider numerator magnitude bits
    localparam int DEN_W = 33;  // divider denominator bits

    typedef enum logic [1:0] {
        ST_TWO   = 2'd0,
        ST_ONE   = 2'd1,
        ST_NONE  = 2'd2,
        ST_DEGEN = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } t_in;

    typedef struct packed {
        logic [1:0]         root_status;
        logic signed [31:0] root_first;
        logic signed [31:0] root_second;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic signed [31:0] coef_b;
        logic [31:0]        mag_b;
        logic [31:0]        mag_c;
        logic [DEN_W-1:0]   mag_a2;
        logic               a_neg;
        logic               a_zero;
        logic               b_neg;
        logic               b_zero;
        logic               c_pos;
        logic               d_neg;
        logic               d_zero;
    } t_sq_side;

    typedef struct packed {
        logic             neg;
        logic [N_W-1:0]   num;
        logic [DEN_W-1:0] den;
    } t_div_op;

    typedef struct packed {
        t_status status;
        logic    use1;
        logic    use2;
    } t_div_side;

    typedef struct packed {
        logic signed [31:0] value;
        logic               ovf;
    } t_root;

endpackage

### hw/rtl/qrs_disc.sv
module qrs_disc (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  qrs_pkg::t_in            i_data,
    output logic                    o_vld,
    output logic [qrs_pkg::D_W-1:0] o_d,
    output qrs_pkg::t_sq_side       o_side
);

    logic [31:0]        w_ra, w_rb, w_rc;
    logic [31:0]        n_ma;
    qrs_pkg::t_sq_side  n_s1_side;

    logic               r_s1_vld, r_s2_vld, r_s3_vld;
    logic [31:0]        r_s1_ma;
    logic               r_s1_ac_neg, r_s2_ac_neg;
    qrs_pkg::t_sq_side  r_s1_side, r_s2_side, r_s3_side;
    logic [63:0]        r_s2_p, r_s2_ac;
    logic [qrs_pkg::D_W-1:0] r_s3_d;

    logic [qrs_pkg::D_W-1:0] w_p, w_q4, w_sum, w_diff;
    logic               w_ge;
    qrs_pkg::t_sq_side  n_s3_side;
    logic [qrs_pkg::D_W-1:0] n_s3_d;

    always_comb begin
        w_ra = i_data.coef_a;
        w_rb = i_data.coef_b;
        w_rc = i_data.coef_c;
        n_ma = w_ra[31] ? (~w_ra + 32'd1) : w_ra;
        n_s1_side.coef_b = i_data.coef_b;
        n_s1_side.mag_b  = w_rb[31] ? (~w_rb + 32'd1) : w_rb;
        n_s1_side.mag_c  = w_rc[31] ? (~w_rc + 32'd1) : w_rc;
        n_s1_side.mag_a2 = {n_ma, 1'b0};
        n_s1_side.a_neg  = w_ra[31];
        n_s1_side.a_zero = (w_ra == 32'd0);
        n_s1_side.b_neg  = w_rb[31];
        n_s1_side.b_zero = (w_rb == 32'd0);
        n_s1_side.c_pos  = !w_rc[31] && (w_rc != 32'd0);
        n_s1_side.d_neg  = 1'b0;
        n_s1_side.d_zero = 1'b0;
    end

    // Sign-magnitude discriminant: 4ac adds when a and c differ in sign.
    always_comb begin
        w_p    = {2'b00, r_s2_p};
        w_q4   = {r_s2_ac, 2'b00};
        w_sum  = w_p + w_q4;
        w_diff = w_p - w_q4;
        w_ge   = (w_p >= w_q4);
        n_s3_side = r_s2_side;
        n_s3_side.d_neg  = !r_s2_ac_neg && !w_ge;
        n_s3_side.d_zero = r_s2_ac_neg ? ((r_s2_p == 64'd0) && (r_s2_ac == 64'd0))
                                       : (w_p == w_q4);
        if (r_s2_ac_neg) begin
            n_s3_d = w_sum;
        end else if (w_ge) begin
            n_s3_d = w_diff;
        end else begin
            n_s3_d = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ma     <= n_ma;
            r_s1_ac_neg <= w_ra[31] ^ w_rc[31];
            r_s1_side   <= n_s1_side;
            r_s2_p      <= r_s1_side.mag_b * r_s1_side.mag_b;
            r_s2_ac     <= r_s1_ma * r_s1_side.mag_c;
            r_s2_ac_neg <= r_s1_ac_neg;
            r_s2_side   <= r_s1_side;
            r_s3_d      <= n_s3_d;
            r_s3_side   <= n_s3_side;
        end
    end

    assign o_vld  = r_s3_vld;
    assign o_d    = r_s3_d;
    assign o_side = r_s3_side;

endmodule

### hw/rtl/qrs_isqrt.sv
module qrs_isqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [qrs_pkg::D_W-1:0] i_d,
    input  qrs_pkg::t_sq_side       i_side,
    output logic                    o_vld,
    output logic [qrs_pkg::R_W-1:0] o_root,
    output qrs_pkg::t_sq_side       o_side
);

    localparam int RW = qrs_pkg::R_W;
    localparam int DW = qrs_pkg::D_W;
    localparam int RM = RW + 2;

    logic              r_vld  [RW];
    logic [RM-1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [DW-1:0]     r_dsh  [RW];
    qrs_pkg::t_sq_side r_side [RW];

    logic [RM-1:0]     w_srem  [RW];
    logic [RW-1:0]     w_sroot [RW];
    logic [DW-1:0]     w_sd    [RW];
    logic [RM+1:0]     w_rem2  [RW];
    logic [RM+1:0]     w_trial [RW];
    logic              w_ge    [RW];
    logic [RM-1:0]     n_rem   [RW];
    logic [RW-1:0]     n_root  [RW];

    // One root bit per stage, two radicand bits consumed per stage.
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            w_srem[k]  = (k == 0) ? '0  : r_rem[(k == 0) ? 0 : k - 1];
            w_sroot[k] = (k == 0) ? '0  : r_root[(k == 0) ? 0 : k - 1];
            w_sd[k]    = (k == 0) ? i_d : r_dsh[(k == 0) ? 0 : k - 1];
            w_rem2[k]  = {w_srem[k], w_sd[k][DW-1:DW-2]};
            w_trial[k] = {2'b00, w_sroot[k], 2'b01};
            w_ge[k]    = (w_rem2[k] >= w_trial[k]);
            n_rem[k]   = w_ge[k] ? RM'(w_rem2[k] - w_trial[k]) : w_rem2[k][RM-1:0];
            n_root[k]  = {w_sroot[k][RW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_dsh[k]  <= {w_sd[k][DW-3:0], 2'b00};
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

### hw/rtl/qrs_div.sv
module qrs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  qrs_pkg::t_div_op [1:0]   i_op,
    input  qrs_pkg::t_div_side       i_side,
    output logic                     o_vld,
    output qrs_pkg::t_root [1:0]     o_root,
    output qrs_pkg::t_div_side       o_side
);

    localparam int DEN = qrs_pkg::DEN_W;
    localparam int NB  = qrs_pkg::N_W + FRAC_BITS;

    logic               r_vld  [NB];
    qrs_pkg::t_div_side r_side [NB];
    logic [DEN-1:0]     r_rem  [2][NB];
    logic [31:0]        r_q    [2][NB];
    logic               r_hi   [2][NB];
    logic [NB-1:0]      r_dvd  [2][NB];
    logic [DEN-1:0]     r_den  [2][NB];
    logic               r_neg  [2][NB];

    logic               r_f_vld;
    qrs_pkg::t_div_side r_f_side;
    qrs_pkg::t_root     r_f_root [2];

    logic [DEN-1:0]     w_srem [2][NB];
    logic [31:0]        w_sq   [2][NB];
    logic               w_shi  [2][NB];
    logic [NB-1:0]      w_sdvd [2][NB];
    logic [DEN-1:0]     w_sden [2][NB];
    logic               w_sneg [2][NB];
    logic [DEN:0]       w_rem2 [2][NB];
    logic               w_ge   [2][NB];
    qrs_pkg::t_root     n_root [2];
    logic [31:0]        w_fq   [2];
    logic               w_fsat [2];

    // Restoring division, one quotient bit per stage; quotient bits above
    // bit 31 only feed the sticky saturation flag.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 0; k < NB; k++) begin
                if (k == 0) begin
                    w_srem[l][k] = '0;
                    w_sq[l][k]   = '0;
                    w_shi[l][k]  = 1'b0;
                    w_sdvd[l][k] = NB'(i_op[l].num) << FRAC_BITS;
                    w_sden[l][k] = i_op[l].den;
                    w_sneg[l][k] = i_op[l].neg;
                end else begin
                    w_srem[l][k] = r_rem[l][k-1];
                    w_sq[l][k]   = r_q[l][k-1];
                    w_shi[l][k]  = r_hi[l][k-1];
                    w_sdvd[l][k] = r_dvd[l][k-1];
                    w_sden[l][k] = r_den[l][k-1];
                    w_sneg[l][k] = r_neg[l][k-1];
                end
                w_rem2[l][k] = {w_srem[l][k], w_sdvd[l][k][NB-1]};
                w_ge[l][k]   = (w_rem2[l][k] >= {1'b0, w_sden[l][k]});
            end
        end
    end

    // Saturate the quotient to the signed 32-bit range.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_fq[l] = r_q[l][NB-1];
            if (r_neg[l][NB-1]) begin
                w_fsat[l] = r_hi[l][NB-1] || (w_fq[l][31] && (w_fq[l][30:0] != 31'd0));
                n_root[l].value = w_fsat[l] ? 32'sh8000_0000 : $signed(~w_fq[l] + 32'd1);
            end else begin
                w_fsat[l] = r_hi[l][NB-1] || w_fq[l][31];
                n_root[l].value = w_fsat[l] ? 32'sh7fff_ffff : $signed(w_fq[l]);
            end
            n_root[l].ovf = w_fsat[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NB; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[(k == 0) ? 0 : k - 1];
            end
            r_f_vld <= r_vld[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
            end
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < NB; k++) begin
                    r_rem[l][k] <= w_ge[l][k] ? DEN'(w_rem2[l][k] - {1'b0, w_sden[l][k]})
                                              : w_rem2[l][k][DEN-1:0];
                    r_q[l][k]   <= {w_sq[l][k][30:0], w_ge[l][k]};
                    r_hi[l][k]  <= w_shi[l][k] | w_sq[l][k][31];
                    r_dvd[l][k] <= w_sdvd[l][k] << 1;
                    r_den[l][k] <= w_sden[l][k];
                    r_neg[l][k] <= w_sneg[l][k];
                end
                r_f_root[l] <= n_root[l];
            end
            r_f_side <= r_side[NB-1];
        end
    end

    assign o_vld     = r_f_vld;
    assign o_side    = r_f_side;
    assign o_root[0] = r_f_root[0];
    assign o_root[1] = r_f_root[1];

endmodule

### hw/rtl/quadratic_root_solver_core.sv
// Quadratic root solver: takes a, b, c of a*x^2 + b*x + c in signed fixed point
// with FRAC_BITS fraction bits and returns the status (two roots, one root, no
// real roots, or degenerate when a and b are both zero), the plus-branch or
// single root, the minus-branch root and a saturation flag. Absent roots read
// as zero. The block accepts one item every cycle while the output buffer has a
// free entry and returns results in order. From acceptance to o_out_valid an item
// passes three stages for the discriminant multiplies, 33 for the bit-per-stage
// square root, one setup stage, 34 + FRAC_BITS restoring divider stages plus a
// saturation stage, and the output register. A two-entry output buffer lets new
// items enter while a result waits; the whole pipeline holds only once both
// entries are full.
`include "assert_macros.svh"

module quadratic_root_solver_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  qrs_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output qrs_pkg::t_out o_out_data
);

    logic                      w_en;
    logic                      w_disc_vld, w_sq_vld, w_div_vld;
    logic [qrs_pkg::D_W-1:0]   w_disc_d;
    qrs_pkg::t_sq_side         w_disc_side, w_sq_side;
    logic [qrs_pkg::R_W-1:0]   w_sq_root;
    qrs_pkg::t_root [1:0]      w_div_root;
    qrs_pkg::t_div_side        w_div_side;

    logic                      r_su_vld;
    qrs_pkg::t_div_op [1:0]    r_su_op;
    qrs_pkg::t_div_side        r_su_side;
    qrs_pkg::t_div_op [1:0]    n_su_op;
    qrs_pkg::t_div_side        n_su_side;

    logic signed [34:0]        w_nb, w_s, w_n1, w_n2;

    logic                      r_out_vld, r_skid_vld;
    qrs_pkg::t_out             r_out, r_skid;
    qrs_pkg::t_out             n_res;
    logic                      w_take;

    logic                      w_out_none, w_out_one, w_roots_zero;

    // Hold every stage while the skid entry is occupied.
    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    qrs_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid && w_en),
        .i_data  (i_in_data),
        .o_vld   (w_disc_vld),
        .o_d     (w_disc_d),
        .o_side  (w_disc_side)
    );

    qrs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_disc_vld),
        .i_d     (w_disc_d),
        .i_side  (w_disc_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Setup stage: pick the case and the divider operands for both lanes.
    always_comb begin
        w_nb = -(35'(w_sq_side.coef_b));
        w_s  = $signed({2'b00, w_sq_root});
        w_n1 = w_nb + w_s;
        w_n2 = w_nb - w_s;

        n_su_op[0].neg = 1'b0;
        n_su_op[0].num = '0;
        n_su_op[0].den = w_sq_side.mag_a2;
        n_su_op[1].neg = w_n2[34] != w_sq_side.a_neg;
        n_su_op[1].num = w_n2[34] ? 34'(-w_n2) : w_n2[33:0];
        n_su_op[1].den = w_sq_side.mag_a2;
        n_su_side.use1 = 1'b0;
        n_su_side.use2 = 1'b0;

        if (w_sq_side.d_neg) begin
            n_su_side.status = qrs_pkg::ST_NONE;
        end else if (w_sq_side.a_zero) begin
            if (w_sq_side.b_zero) begin
                n_su_side.status = qrs_pkg::ST_DEGEN;
            end else begin
                // Linear root -c/b.
                n_su_side.status = qrs_pkg::ST_ONE;
                n_su_side.use1   = 1'b1;
                n_su_op[0].neg   = w_sq_side.c_pos != w_sq_side.b_neg;
                n_su_op[0].num   = {2'b00, w_sq_side.mag_c};
                n_su_op[0].den   = {1'b0, w_sq_side.mag_b};
            end
        end else if (w_sq_side.d_zero) begin
            // Repeated root -b/2a.
            n_su_side.status = qrs_pkg::ST_ONE;
            n_su_side.use1   = 1'b1;
            n_su_op[0].neg   = (!w_sq_side.b_neg && !w_sq_side.b_zero) != w_sq_side.a_neg;
            n_su_op[0].num   = {2'b00, w_sq_side.mag_b};
        end else begin
            n_su_side.status = qrs_pkg::ST_TWO;
            n_su_side.use1   = 1'b1;
            n_su_side.use2   = 1'b1;
            n_su_op[0].neg   = w_n1[34] != w_sq_side.a_neg;
            n_su_op[0].num   = w_n1[34] ? 34'(-w_n1) : w_n1[33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_vld <= 1'b0;
        end else if (w_en) begin
            r_su_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_su_op   <= n_su_op;
            r_su_side <= n_su_side;
        end
    end

    qrs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_su_vld),
        .i_op    (r_su_op),
        .i_side  (r_su_side),
        .o_vld   (w_div_vld),
        .o_root  (w_div_root),
        .o_side  (w_div_side)
    );

    // Drop roots that the case does not use; they read as zero.
    always_comb begin
        n_res.root_status = w_div_side.status;
        n_res.root_first  = w_div_side.use1 ? w_div_root[0].value : 32'sd0;
        n_res.root_second = w_div_side.use2 ? w_div_root[1].value : 32'sd0;
        n_res.overflow    = (w_div_side.use1 && w_div_root[0].ovf) ||
                            (w_div_side.use2 && w_div_root[1].ovf);
    end

    assign w_take = r_out_vld && i_out_ready;

    // Output register plus skid entry. When the pipeline advances the skid
    // entry is empty, so a new item goes to the output register if that is
    // free or being taken, else into the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en && w_div_vld) begin
                if (!r_out_vld || w_take) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_take) begin
                if (r_skid_vld) begin
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_div_vld) begin
            if (!r_out_vld || w_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (w_take && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_out_none   = r_out_vld && (r_out.root_status == qrs_pkg::ST_NONE);
    assign w_out_one    = r_out_vld && (r_out.root_status == qrs_pkg::ST_ONE);
    assign w_roots_zero = (r_out.root_first == 32'sd0) && (r_out.root_second == 32'sd0);

    `QRS_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !r_skid_vld || r_out_vld)
    `QRS_ASSERT(a_none_is_empty, i_clk, i_rst_n, !w_out_none || (w_roots_zero && !r_out.overflow))
    `QRS_ASSERT(a_one_no_second, i_clk, i_rst_n, !w_out_one || r_out.root_second == 32'sd0)
    `QRS_ASSERT_NEVER(a_skid_fill_held, i_clk, i_rst_n, $rose(r_skid_vld) && !$past(r_out_vld))

endmodule

### tb/sv/tb_quadratic_root_solver_core.sv
module tb_quadratic_root_solver_core;

    localparam int FRAC       = 16;
    localparam int LATENCY    = 73 + FRAC;
    localparam int WATCHDOG   = 4000;
    localparam int N_RANDOM   = 700;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    qrs_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    qrs_pkg::t_out o_out_data;

    // Queues: coefficient sets waiting to be driven, and predicted solutions.
    qrs_pkg::t_in  coef_pending[$];
    qrs_pkg::t_out roots_expected[$];

    int  n_errors = 0;
    int  idle_count;
    bit  hold_sink;      // request a long receiver hold-off
    bit  hold_done;
    int  sink_hold_left;
    bit  src_pause;      // pause the sender until every result is back
    bit  in_taken;       // an item was accepted at the last rising edge
    bit  out_taken;      // a result was accepted at the last rising edge

    quadratic_root_solver_core #(.FRAC_BITS(FRAC)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Truncated scaled quotient with saturation to 32 bits.
    function automatic logic signed [31:0] scaled_quotient(input bit neg,
                                                           input logic [63:0] num,
                                                           input logic [63:0] den,
                                                           inout bit ovf);
        logic [127:0] q;
        q = ({64'd0, num} << FRAC) / {64'd0, den};
        if (!neg) begin
            if (q > 128'h7FFF_FFFF) begin
                ovf = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return -q[31:0];
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] d);
        logic [63:0] res;
        logic [63:0] cand;
        res = 64'd0;
        for (int i = 33; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= d) res = cand;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Predict the solver's answer for one coefficient set.
    function automatic qrs_pkg::t_out solve_roots(input qrs_pkg::t_in c_in);
        qrs_pkg::t_out r;
        longint        a, b, c, s, n1, n2;
        logic [127:0]  bb, ac4, d;
        bit            ovf;
        a = c_in.coef_a;
        b = c_in.coef_b;
        c = c_in.coef_c;
        r = '0;
        ovf = 1'b0;
        bb  = {64'd0, magnitude(b)} * {64'd0, magnitude(b)};
        ac4 = ({64'd0, magnitude(a)} * {64'd0, magnitude(c)}) << 2;
        if ((a < 0) != (c < 0)) d = bb + ac4;
        else if (bb >= ac4) d = bb - ac4;
        else begin
            r.root_status = qrs_pkg::ST_NONE;
            return r;
        end
        if (a == 0) begin
            if (b == 0) r.root_status = qrs_pkg::ST_DEGEN;
            else begin
                r.root_status = qrs_pkg::ST_ONE;
                r.root_first = scaled_quotient((c > 0) != (b < 0), magnitude(c),
                                               magnitude(b), ovf);
            end
        end else if (d == 0) begin
            r.root_status = qrs_pkg::ST_ONE;
            r.root_first = scaled_quotient((b > 0) != (a < 0), magnitude(b),
                                           2 * magnitude(a), ovf);
        end else begin
            s  = isqrt(d);
            n1 = -b + s;
            n2 = -b - s;
            r.root_status = qrs_pkg::ST_TWO;
            r.root_first  = scaled_quotient((n1 < 0) != (a < 0), magnitude(n1),
                                            2 * magnitude(a), ovf);
            r.root_second = scaled_quotient((n2 < 0) != (a < 0), magnitude(n2),
                                            2 * magnitude(a), ovf);
        end
        r.overflow = ovf;
        return r;
    endfunction

    function automatic qrs_pkg::t_in make_coefs(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c);
        qrs_pkg::t_in t;
        t.coef_a = a;
        t.coef_b = b;
        t.coef_c = c;
        return t;
    endfunction

    // Random field: mostly modest values so roots stay in range, sometimes raw bits or the extremes.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
            default: return ($signed($urandom_range(0, 20)) - 32'sd10) <<< FRAC;
        endcase
    endfunction

    // Record handshakes at the rising edge and predict each accepted item.
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            roots_expected.push_back(solve_roots(i_in_data));
    end

    // Driver: take the next coefficient set at the falling edge after a random gap.
    int src_gap;
    always @(negedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            src_gap    <= 0;
        end else begin
            if (in_taken) void'(coef_pending.pop_front());
            if (i_in_valid && !in_taken) begin
                // hold the item until accepted
            end else if (in_taken) begin
                g = $urandom_range(0, 8);
                if (g == 0 && !src_pause && coef_pending.size() != 0) begin
                    i_in_data  <= coef_pending[0];
                    i_in_valid <= 1'b1;
                    src_gap    <= 0;
                end else begin
                    i_in_valid <= 1'b0;
                    src_gap    <= g;
                end
            end else if (src_gap > 1) begin
                src_gap <= src_gap - 1;
            end else if (!src_pause && coef_pending.size() != 0) begin
                src_gap    <= 0;
                i_in_data  <= coef_pending[0];
                i_in_valid <= 1'b1;
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        qrs_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (roots_expected.size() == 0) begin
                $error("unexpected result %p", o_out_data);
                n_errors++;
            end else begin
                exp_r = roots_expected.pop_front();
                if (o_out_data.root_status !== exp_r.root_status) begin
                    $error("root_status exp %0d got %0d", exp_r.root_status,
                           o_out_data.root_status);
                    n_errors++;
                end
                if (o_out_data.root_first !== exp_r.root_first) begin
                    $error("root_first exp %0d got %0d", exp_r.root_first,
                           o_out_data.root_first);
                    n_errors++;
                end
                if (o_out_data.root_second !== exp_r.root_second) begin
                    $error("root_second exp %0d got %0d", exp_r.root_second,
                           o_out_data.root_second);
                    n_errors++;
                end
                if (o_out_data.overflow !== exp_r.overflow) begin
                    $error("overflow exp %0d got %0d", exp_r.overflow,
                           o_out_data.overflow);
                    n_errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    int sink_gap;
    always @(negedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            i_out_ready    <= 1'b0;
            sink_gap       <= 0;
            sink_hold_left <= 0;
            hold_done      <= 1'b0;
        end else if (hold_sink && !hold_done) begin
            hold_done      <= 1'b1;
            sink_hold_left <= 400;
            i_out_ready    <= 1'b0;
        end else if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            i_out_ready    <= 1'b0;
        end else if (out_taken) begin
            // a result moved at the last edge: draw the next stall
            g = $urandom_range(0, 8);
            sink_gap    <= g;
            i_out_ready <= (g == 0);
        end else if (sink_gap > 1) begin
            sink_gap    <= sink_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            sink_gap    <= 0;
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG) begin
            $display("tb_quadratic_root_solver_core: done, errors");
            $finish;
        end
    end

    initial begin
        hold_sink     = 1'b0;
        src_pause     = 1'b0;
        i_rst_n       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each status, degenerate with any c, saturation.
        coef_pending.push_back(make_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000));
        coef_pending.push_back(make_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000));
        coef_pending.push_back(make_coefs(32'h0001_0000, 32'h0, 32'h0001_0000));
        coef_pending.push_back(make_coefs(32'h0, 32'h0, 32'h0));
        coef_pending.push_back(make_coefs(32'h0, 32'h0, 32'h8000_0000));
        coef_pending.push_back(make_coefs(32'h0, 32'h0, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h0, 32'h0002_0000, 32'hFFFC_0000));
        coef_pending.push_back(make_coefs(32'h0, 32'h1, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h0, 32'h8000_0000, 32'h8000_0000));
        coef_pending.push_back(make_coefs(32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
        coef_pending.push_back(make_coefs(32'h1, 32'h7FFF_FFFF, 32'h0));
        coef_pending.push_back(make_coefs(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        coef_pending.push_back(make_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h8000_0000, 32'h0, 32'h8000_0000));
        coef_pending.push_back(make_coefs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF));
        coef_pending.push_back(make_coefs(32'h1, 32'h2, 32'h1));
        coef_pending.push_back(make_coefs(32'hFFFF_0000, 32'h0004_0000, 32'hFFFC_0000));
        coef_pending.push_back(make_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        for (int i = 0; i < N_RANDOM; i++) begin
            coef_pending.push_back(make_coefs(rand_coef(), rand_coef(), rand_coef()));
            // Mid-run: stall the receiver so the pipeline backs up.
            if (i == 200) begin
                wait (coef_pending.size() < 150);
                hold_sink = 1'b1;
            end
            // Later: let the sender drain, then pause it until every result is back.
            if (i == 450) begin
                wait (coef_pending.size() == 0);
                src_pause = 1'b1;
                wait (roots_expected.size() == 0 && !i_in_valid);
                src_pause = 1'b0;
            end
        end

        wait (coef_pending.size() == 0 && !i_in_valid);
        wait (roots_expected.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && roots_expected.size() == 0)
            $display("tb_quadratic_root_solver_core: done, clean");
        else
            $display("tb_quadratic_root_solver_core: done, errors");
        $finish;
    end
endmodule
